// ===== design/timetable_segment_crossing_unit_assert.svh =====
// Assertion macros for the timetable segment crossing unit
`ifndef TIMETABLE_SEGMENT_CROSSING_UNIT_ASSERT_SVH
`define TIMETABLE_SEGMENT_CROSSING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timetable segment crossing check failed");
`define TSC_ASSERT_DLY(lbl, clk, rst, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("timetable segment crossing latency check failed");
`else
`define TSC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TSC_ASSERT_DLY(lbl, clk, rst, ante, n, cons)
`endif
`endif

// ===== design/tsc_pkg.sv =====
// Types and constants of the timetable segment crossing unit
`default_nettype none
package tsc_pkg;
  localparam int unsigned DAY_MS = 86400000;
  localparam int TW    = 27;
  localparam int XW    = 28;
  localparam int YW    = 20;
  localparam int MW    = 24;
  localparam int DXW   = 29;
  localparam int DYW   = 21;
  localparam int PW    = 50;
  localparam int SW    = 51;
  localparam int DW    = 50;
  localparam int VW    = 28;
  localparam int QW    = 28;
  localparam int NSTEP = QW;
  localparam int LAT   = NSTEP + 9;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_COINC,
    KIND_OVERTAKE,
    KIND_AVOID,
    KIND_MEET
  } kind_t;

  typedef struct packed {
    logic [VW-1:0] v1;
    logic [VW-1:0] v2;
    logic [DW-1:0] p;
    logic [DW-1:0] den;
  } raw_t;

  typedef struct packed {
    logic [QW-1:0] a;
    logic [DW-1:0] p;
    logic [DW-1:0] den;
    logic [VW-1:0] base;
    logic [DW-1:0] r;
    logic [QW-1:0] q;
  } lane_t;
endpackage
`default_nettype wire

// ===== design/timetable_segment_crossing_unit.sv =====
// Timetable segment crossing unit: pipelined crossing detector for two run segments
//
// An item is a pair of run segments, presented on the input ports with start
// high; it is taken at a rising edge where start is high and busy is low.
// busy stays low, so a new item may be taken in every cycle.
// Each item gives exactly one result, shown on event_kind, event_time and
// event_mile for one cycle while done is high; the receiver cannot stall.
// An item passes these stages from the accepting edge to the edge that takes the
// result: six stages of wrap, differences, products, determinant, sign
// normalisation and classification, one operand setup stage, 28 stages of
// the pipelined rounding divider (one quotient bit of the interpolated span
// per stage) and two stages for rounding and the day wrap.
// Throughput is one item per cycle, set by the fully pipelined divider.
// Reset clears every valid bit, so no result appears until items are taken.
`default_nettype none
`include "timetable_segment_crossing_unit_assert.svh"
module timetable_segment_crossing_unit
  import tsc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          mode,
  input  wire logic [TW-1:0] my_start_time,
  input  wire logic [TW-1:0] my_end_time,
  input  wire logic [YW-1:0] my_start_y,
  input  wire logic [YW-1:0] my_end_y,
  input  wire logic [MW-1:0] my_start_mile,
  input  wire logic [MW-1:0] my_end_mile,
  input  wire logic [TW-1:0] his_first_time,
  input  wire logic [TW-1:0] his_second_time,
  input  wire logic [YW-1:0] his_first_y,
  input  wire logic [YW-1:0] his_second_y,
  input  wire logic [MW-1:0] his_first_mile,
  output logic               done,
  output logic [2:0]         event_kind,
  output logic [TW-1:0]      event_time,
  output logic [MW-1:0]      event_mile
);

  localparam logic [XW-1:0] DAY_X   = XW'(DAY_MS);
  localparam logic [VW:0]   DAY_S   = (VW + 1)'(DAY_MS);
  localparam logic [VW:0]   DAY2_S  = (VW + 1)'(2 * DAY_MS);

  function automatic logic in_range(input logic [YW-1:0] v, input logic [YW-1:0] a,
                                    input logic [YW-1:0] b);
    return (a <= b) ? (a <= v && v <= b) : (b <= v && v <= a);
  endfunction

  function automatic raw_t mk_raw(input logic [VW-1:0] v1, input logic [VW-1:0] v2,
                                  input logic [DW-1:0] p, input logic [DW-1:0] den);
    raw_t x;
    x.v1  = v1;
    x.v2  = v2;
    x.p   = p;
    x.den = den;
    return x;
  endfunction

  function automatic raw_t fix(input logic [VW-1:0] v);
    return mk_raw(v, v, '0, DW'(1));
  endfunction

  function automatic lane_t lane_setup(input raw_t x);
    lane_t l;
    logic  dir;
    dir    = x.v2 >= x.v1;
    l.a    = dir ? QW'(x.v2 - x.v1) : QW'(x.v1 - x.v2);
    l.p    = dir ? x.p : x.den - x.p;
    l.den  = x.den;
    l.base = dir ? x.v1 : x.v2;
    l.r    = '0;
    l.q    = '0;
    return l;
  endfunction

  function automatic lane_t lane_step(input lane_t l);
    lane_t         o;
    logic [DW+1:0] t;
    logic [DW+1:0] d1;
    logic [DW+1:0] d2;
    logic [1:0]    d;
    logic [QW:0]   qs;
    t  = {1'b0, l.r, 1'b0} + (l.a[QW-1] ? {2'b00, l.p} : '0);
    d1 = {2'b00, l.den};
    d2 = {1'b0, l.den, 1'b0};
    o  = l;
    if (t >= d2) begin
      o.r = DW'(t - d2);
      d   = 2'd2;
    end else if (t >= d1) begin
      o.r = DW'(t - d1);
      d   = 2'd1;
    end else begin
      o.r = DW'(t);
      d   = 2'd0;
    end
    qs  = {l.q, 1'b0} + {{(QW - 1){1'b0}}, d};
    o.q = qs[QW-1:0];
    o.a = {l.a[QW-2:0], 1'b0};
    return o;
  endfunction

  assign busy = 1'b0;

  // stage 1: wrap
  logic            s1_v;
  logic            s1_same;
  logic [XW-1:0]   s1_xm1, s1_xm2, s1_xh1, s1_xh2;
  logic [YW-1:0]   s1_ym1, s1_ym2, s1_yh1, s1_yh2;
  logic [MW-1:0]   s1_m1, s1_m2, s1_mh1;
  logic [XW-1:0]   w_xm2, w_xh1, w_xh2, w_f, w_s;

  always_comb begin
    w_f   = {1'b0, his_first_time};
    w_s   = {1'b0, his_second_time};
    w_xm2 = (my_end_time < my_start_time) ? {1'b0, my_end_time} + DAY_X : {1'b0, my_end_time};
    w_xh1 = w_f;
    w_xh2 = w_s;
    if (!mode) begin
      if (w_s < w_f) w_xh2 = w_s + DAY_X;
    end else begin
      if (w_f < w_s) w_xh1 = w_f + DAY_X;
    end
  end

  always_ff @(posedge clk) begin
    s1_same <= ~mode;
    s1_xm1  <= {1'b0, my_start_time};
    s1_xm2  <= w_xm2;
    s1_xh1  <= w_xh1;
    s1_xh2  <= w_xh2;
    s1_ym1  <= my_start_y;
    s1_ym2  <= my_end_y;
    s1_yh1  <= his_first_y;
    s1_yh2  <= his_second_y;
    s1_m1   <= my_start_mile;
    s1_m2   <= my_end_mile;
    s1_mh1  <= his_first_mile;
  end

  // stage 2: differences and overlap
  logic                  s2_v, s2_same, s2_nov, s2_win_m, s2_win_h, s2_mfirst;
  logic signed [DXW-1:0] s2_dxm, s2_dxh, s2_ex;
  logic signed [DYW-1:0] s2_dym, s2_dyh, s2_ey;
  logic [XW-1:0]         s2_xm1, s2_xm2, s2_xh1, s2_xh2;
  logic [MW-1:0]         s2_m1, s2_m2, s2_mh1;
  logic [XW-1:0]         c2_hs, c2_he, c2_lo, c2_hi;

  always_comb begin
    c2_hs = s1_same ? s1_xh1 : s1_xh2;
    c2_he = s1_same ? s1_xh2 : s1_xh1;
    c2_lo = (s1_xm1 > c2_hs) ? s1_xm1 : c2_hs;
    c2_hi = (s1_xm2 < c2_he) ? s1_xm2 : c2_he;
  end

  always_ff @(posedge clk) begin
    s2_same   <= s1_same;
    s2_nov    <= c2_lo > c2_hi;
    s2_win_m  <= in_range(s1_ym1, s1_yh1, s1_yh2);
    s2_win_h  <= in_range(s1_yh1, s1_ym1, s1_ym2);
    s2_mfirst <= s1_xm1 <= s1_xh1;
    s2_dxm    <= $signed({1'b0, s1_xm2}) - $signed({1'b0, s1_xm1});
    s2_dxh    <= $signed({1'b0, s1_xh2}) - $signed({1'b0, s1_xh1});
    s2_ex     <= $signed({1'b0, s1_xh1}) - $signed({1'b0, s1_xm1});
    s2_dym    <= $signed({1'b0, s1_ym2}) - $signed({1'b0, s1_ym1});
    s2_dyh    <= $signed({1'b0, s1_yh2}) - $signed({1'b0, s1_yh1});
    s2_ey     <= $signed({1'b0, s1_yh1}) - $signed({1'b0, s1_ym1});
    s2_xm1    <= s1_xm1;
    s2_xm2    <= s1_xm2;
    s2_xh1    <= s1_xh1;
    s2_xh2    <= s1_xh2;
    s2_m1     <= s1_m1;
    s2_m2     <= s1_m2;
    s2_mh1    <= s1_mh1;
  end

  // stage 3: products
  logic                 s3_v, s3_same, s3_nov, s3_win_m, s3_win_h, s3_mfirst;
  logic                 s3_vm, s3_vh, s3_dym_zero, s3_dyh_zero;
  logic signed [PW-1:0] s3_p1, s3_p2, s3_p3, s3_p4, s3_p5, s3_p6;
  logic [YW-1:0]        s3_abs_ey, s3_abs_dym;
  logic [XW-1:0]        s3_xm1, s3_xm2, s3_xh1, s3_xh2;
  logic [MW-1:0]        s3_m1, s3_m2, s3_mh1;

  always_ff @(posedge clk) begin
    s3_same     <= s2_same;
    s3_nov      <= s2_nov;
    s3_win_m    <= s2_win_m;
    s3_win_h    <= s2_win_h;
    s3_mfirst   <= s2_mfirst;
    s3_vm       <= s2_dxm == '0;
    s3_vh       <= s2_dxh == '0;
    s3_dym_zero <= s2_dym == '0;
    s3_dyh_zero <= s2_dyh == '0;
    s3_p1       <= s2_dxh * s2_dym;
    s3_p2       <= s2_dxm * s2_dyh;
    s3_p3       <= s2_dxh * s2_ey;
    s3_p4       <= s2_ex * s2_dyh;
    s3_p5       <= s2_dxm * s2_ey;
    s3_p6       <= s2_ex * s2_dym;
    s3_abs_ey   <= s2_ey[DYW-1] ? YW'(-s2_ey) : YW'(s2_ey);
    s3_abs_dym  <= s2_dym[DYW-1] ? YW'(-s2_dym) : YW'(s2_dym);
    s3_xm1      <= s2_xm1;
    s3_xm2      <= s2_xm2;
    s3_xh1      <= s2_xh1;
    s3_xh2      <= s2_xh2;
    s3_m1       <= s2_m1;
    s3_m2       <= s2_m2;
    s3_mh1      <= s2_mh1;
  end

  // stage 4: determinant and numerators
  logic                 s4_v, s4_same, s4_nov, s4_win_m, s4_win_h, s4_mfirst;
  logic                 s4_vm, s4_vh, s4_dym_zero, s4_dyh_zero;
  logic signed [SW-1:0] s4_det, s4_tn, s4_sn;
  logic [PW-1:0]        s4_a1, s4_a2;
  logic [YW-1:0]        s4_abs_ey, s4_abs_dym;
  logic [XW-1:0]        s4_xm1, s4_xm2, s4_xh1, s4_xh2;
  logic [MW-1:0]        s4_m1, s4_m2, s4_mh1;

  always_ff @(posedge clk) begin
    s4_same     <= s3_same;
    s4_nov      <= s3_nov;
    s4_win_m    <= s3_win_m;
    s4_win_h    <= s3_win_h;
    s4_mfirst   <= s3_mfirst;
    s4_vm       <= s3_vm;
    s4_vh       <= s3_vh;
    s4_dym_zero <= s3_dym_zero;
    s4_dyh_zero <= s3_dyh_zero;
    s4_det      <= SW'(s3_p1) - SW'(s3_p2);
    s4_tn       <= SW'(s3_p3) - SW'(s3_p4);
    s4_sn       <= SW'(s3_p5) - SW'(s3_p6);
    s4_a1       <= s3_p1[PW-1] ? PW'(-s3_p1) : PW'(s3_p1);
    s4_a2       <= s3_p2[PW-1] ? PW'(-s3_p2) : PW'(s3_p2);
    s4_abs_ey   <= s3_abs_ey;
    s4_abs_dym  <= s3_abs_dym;
    s4_xm1      <= s3_xm1;
    s4_xm2      <= s3_xm2;
    s4_xh1      <= s3_xh1;
    s4_xh2      <= s3_xh2;
    s4_m1       <= s3_m1;
    s4_m2       <= s3_m2;
    s4_mh1      <= s3_mh1;
  end

  // stage 5: sign normalisation
  logic                 s5_v, s5_same, s5_nov, s5_win_m, s5_win_h, s5_mfirst;
  logic                 s5_vm, s5_vh, s5_dym_zero, s5_dyh_zero;
  logic                 s5_det_zero, s5_tn_zero, s5_sn_zero, s5_steep;
  logic [DW-1:0]        s5_detn;
  logic signed [SW-1:0] s5_tnn, s5_snn;
  logic [YW-1:0]        s5_abs_ey, s5_abs_dym;
  logic [XW-1:0]        s5_xm1, s5_xm2, s5_xh1, s5_xh2;
  logic [MW-1:0]        s5_m1, s5_m2, s5_mh1;

  always_ff @(posedge clk) begin
    s5_same     <= s4_same;
    s5_nov      <= s4_nov;
    s5_win_m    <= s4_win_m;
    s5_win_h    <= s4_win_h;
    s5_mfirst   <= s4_mfirst;
    s5_vm       <= s4_vm;
    s5_vh       <= s4_vh;
    s5_dym_zero <= s4_dym_zero;
    s5_dyh_zero <= s4_dyh_zero;
    s5_det_zero <= s4_det == '0;
    s5_tn_zero  <= s4_tn == '0;
    s5_sn_zero  <= s4_sn == '0;
    s5_steep    <= s4_a1 > s4_a2;
    s5_detn     <= s4_det[SW-1] ? DW'(-s4_det) : DW'(s4_det);
    s5_tnn      <= s4_det[SW-1] ? -s4_tn : s4_tn;
    s5_snn      <= s4_det[SW-1] ? -s4_sn : s4_sn;
    s5_abs_ey   <= s4_abs_ey;
    s5_abs_dym  <= s4_abs_dym;
    s5_xm1      <= s4_xm1;
    s5_xm2      <= s4_xm2;
    s5_xh1      <= s4_xh1;
    s5_xh2      <= s4_xh2;
    s5_m1       <= s4_m1;
    s5_m2       <= s4_m2;
    s5_mh1      <= s4_mh1;
  end

  // stage 6: classification
  logic                 s6_v;
  kind_t                s6_kind;
  raw_t                 s6_rt, s6_rm;
  kind_t                c6_kind;
  raw_t                 c6_rt, c6_rm;
  logic signed [SW-1:0] c6_detx;
  logic                 c6_tn_ok, c6_sn_ok, c6_par, c6_coinc;

  always_comb begin
    c6_detx  = $signed({1'b0, s5_detn});
    c6_tn_ok = !s5_tnn[SW-1] && (s5_tnn <= c6_detx);
    c6_sn_ok = !s5_snn[SW-1] && (s5_snn <= c6_detx);
    c6_par   = (s5_vm && s5_vh) || (!s5_vm && !s5_vh && s5_det_zero);
    c6_coinc = (s5_vm && s5_vh) || s5_sn_zero;
    c6_kind  = KIND_NONE;
    c6_rt    = fix('0);
    c6_rm    = fix('0);
    if (!s5_nov) begin
      if (c6_par) begin
        if (c6_coinc) begin
          c6_kind = KIND_COINC;
          if (s5_mfirst) begin
            c6_rt = fix(s5_xm1);
            c6_rm = fix(VW'(s5_m1));
          end else begin
            c6_rt = fix(s5_xh1);
            c6_rm = fix(VW'(s5_mh1));
          end
        end
      end else if (s5_det_zero) begin
        if (s5_vm) begin
          if (s5_tn_zero && s5_win_m) begin
            c6_kind = s5_same ? KIND_OVERTAKE : KIND_MEET;
            c6_rt   = fix(s5_xm1);
            c6_rm   = fix(VW'(s5_m1));
          end
        end else if (s5_sn_zero && s5_win_h) begin
          c6_kind = s5_same ? KIND_AVOID : KIND_MEET;
          c6_rt   = fix(s5_xh1);
          c6_rm   = s5_dym_zero ? fix(VW'(s5_m1)) :
                    mk_raw(VW'(s5_m1), VW'(s5_m2), DW'(s5_abs_ey), DW'(s5_abs_dym));
        end
      end else if (!((!s5_dym_zero && !c6_tn_ok) || (!s5_dyh_zero && !c6_sn_ok))) begin
        c6_rt = !s5_dym_zero ? mk_raw(s5_xm1, s5_xm2, DW'(s5_tnn), s5_detn) :
                               mk_raw(s5_xh1, s5_xh2, DW'(s5_snn), s5_detn);
        c6_rm = (!s5_vm && !s5_dym_zero) ?
                mk_raw(VW'(s5_m1), VW'(s5_m2), DW'(s5_tnn), s5_detn) : fix(VW'(s5_m1));
        if (!s5_same) c6_kind = KIND_MEET;
        else if (s5_vm) c6_kind = KIND_OVERTAKE;
        else if (s5_vh) c6_kind = KIND_AVOID;
        else c6_kind = s5_steep ? KIND_OVERTAKE : KIND_AVOID;
      end
    end
  end

  always_ff @(posedge clk) begin
    s6_kind <= c6_kind;
    s6_rt   <= c6_rt;
    s6_rm   <= c6_rm;
  end

  // stages 7 and on: operand setup and pipelined rounding divider
  logic [NSTEP:0] dv;
  kind_t          dk [0:NSTEP];
  lane_t          tl [0:NSTEP];
  lane_t          ml [0:NSTEP];

  always_ff @(posedge clk) begin
    dk[0] <= s6_kind;
    tl[0] <= lane_setup(s6_rt);
    ml[0] <= lane_setup(s6_rm);
    for (int i = 0; i < NSTEP; i++) begin
      dk[i+1] <= dk[i];
      tl[i+1] <= lane_step(tl[i]);
      ml[i+1] <= lane_step(ml[i]);
    end
  end

  // round and add base
  logic        f1_v;
  kind_t       f1_kind;
  logic [VW:0] f1_t, f1_m;
  logic        c_rt, c_rm;

  always_comb begin
    c_rt = {tl[NSTEP].r, 1'b0} >= {1'b0, tl[NSTEP].den};
    c_rm = {ml[NSTEP].r, 1'b0} >= {1'b0, ml[NSTEP].den};
  end

  always_ff @(posedge clk) begin
    f1_kind <= dk[NSTEP];
    f1_t    <= {1'b0, tl[NSTEP].base} + {1'b0, tl[NSTEP].q} + {{VW{1'b0}}, c_rt};
    f1_m    <= {1'b0, ml[NSTEP].base} + {1'b0, ml[NSTEP].q} + {{VW{1'b0}}, c_rm};
  end

  // wrap into one day and drive the result
  kind_t out_kind;

  always_ff @(posedge clk) begin
    out_kind   <= f1_kind;
    event_mile <= MW'(f1_m);
    if (f1_t >= DAY2_S) begin
      event_time <= TW'(f1_t - DAY2_S);
    end else if (f1_t >= DAY_S) begin
      event_time <= TW'(f1_t - DAY_S);
    end else begin
      event_time <= TW'(f1_t);
    end
  end

  assign event_kind = out_kind;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      dv   <= '0;
      f1_v <= 1'b0;
      done <= 1'b0;
    end else begin
      s1_v <= start && !busy;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      dv   <= {dv[NSTEP-1:0], s6_v};
      f1_v <= dv[NSTEP];
      done <= f1_v;
    end
  end

  `TSC_ASSERT_DLY(a_latency, clk, rst, start && !busy, LAT, done)
  `TSC_ASSERT_IMP(a_none_zero, clk, rst, done && out_kind == KIND_NONE,
                  event_time == '0 && event_mile == '0)
  `TSC_ASSERT_IMP(a_time_wrapped, clk, rst, done, event_time < TW'(DAY_MS))
  `TSC_ASSERT_IMP(a_rem_bound, clk, rst, dv[NSTEP],
                  tl[NSTEP].r < tl[NSTEP].den && ml[NSTEP].r < ml[NSTEP].den)

endmodule
`default_nettype wire

// ===== test/timetable_segment_crossing_checker.sv =====
// Checker for the timetable segment crossing unit: predicts each crossing result and compares
module timetable_segment_crossing_checker
  import tsc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  logic          mode,
  input  logic [TW-1:0] my_start_time,
  input  logic [TW-1:0] my_end_time,
  input  logic [YW-1:0] my_start_y,
  input  logic [YW-1:0] my_end_y,
  input  logic [MW-1:0] my_start_mile,
  input  logic [MW-1:0] my_end_mile,
  input  logic [TW-1:0] his_first_time,
  input  logic [TW-1:0] his_second_time,
  input  logic [YW-1:0] his_first_y,
  input  logic [YW-1:0] his_second_y,
  input  logic [MW-1:0] his_first_mile,
  input  logic          done,
  input  logic [2:0]    event_kind,
  input  logic [TW-1:0] event_time,
  input  logic [MW-1:0] event_mile,
  output int            fail_count,
  output int            pending,
  output int            kind_seen [5]
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t         kind;
    logic [TW-1:0] t;
    logic [MW-1:0] mile;
  } crossing_t;

  crossing_t crossing_q[$];
  int mismatches;

  function automatic longint round_scaled(longint a, longint b, longint c);
    logic [127:0] num;
    logic [127:0] q;
    num = 128'(a) * 128'(b) * 2 + 128'(c);
    q = num / (128'(c) * 2);
    return longint'(q[63:0]);
  endfunction

  function automatic longint interp(longint v1, longint v2, longint p, longint den);
    if (v2 >= v1) return v1 + round_scaled(v2 - v1, p, den);
    return v2 + round_scaled(v1 - v2, den - p, den);
  endfunction

  function automatic bit in_span(longint v, longint a, longint b);
    return (a <= b) ? (a <= v && v <= b) : (b <= v && v <= a);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic crossing_t pack_event(kind_t k, longint t, longint m);
    crossing_t c;
    if (m < 0) m = 0;
    if (m > 64'hFFFFFF) m = 64'hFFFFFF;
    if (t < 0) t = 0;
    c.kind = k;
    c.t = TW'(t % longint'(DAY_MS));
    c.mile = MW'(m);
    return c;
  endfunction

  function automatic crossing_t predict_crossing();
    bit same;
    bit vm, vh;
    longint xm1, xm2, ym1, ym2, m1, m2, xh1, xh2, yh1, yh2, mh1;
    longint lo, hi, dxm, dym, dxh, dyh, det, tn, sn, t, mile;
    same = !mode;
    xm1 = longint'(my_start_time); xm2 = longint'(my_end_time);
    ym1 = longint'(my_start_y); ym2 = longint'(my_end_y);
    m1 = longint'(my_start_mile); m2 = longint'(my_end_mile);
    xh1 = longint'(his_first_time); xh2 = longint'(his_second_time);
    yh1 = longint'(his_first_y); yh2 = longint'(his_second_y);
    mh1 = longint'(his_first_mile);
    if (xm2 < xm1) xm2 += longint'(DAY_MS);
    if (same) begin
      if (xh2 < xh1) xh2 += longint'(DAY_MS);
      lo = xm1 > xh1 ? xm1 : xh1;
      hi = xm2 < xh2 ? xm2 : xh2;
    end else begin
      if (xh1 < xh2) xh1 += longint'(DAY_MS);
      lo = xm1 > xh2 ? xm1 : xh2;
      hi = xm2 < xh1 ? xm2 : xh1;
    end
    if (lo > hi) return pack_event(KIND_NONE, 0, 0);
    dxm = xm2 - xm1; dym = ym2 - ym1;
    dxh = xh2 - xh1; dyh = yh2 - yh1;
    vm = dxm == 0; vh = dxh == 0;
    if ((vm && vh) || (!vm && !vh && dym * dxh == dyh * dxm)) begin
      if ((vm && vh) || (yh1 - ym1) * dxm == dym * (xh1 - xm1)) begin
        if (xm1 <= xh1) return pack_event(KIND_COINC, xm1, m1);
        return pack_event(KIND_COINC, xh1, mh1);
      end
      return pack_event(KIND_NONE, 0, 0);
    end
    det = dxh * dym - dxm * dyh;
    if (det == 0) begin
      if (vm) begin
        if ((ym1 - yh1) * dxh == dyh * (xm1 - xh1) && in_span(ym1, yh1, yh2))
          return pack_event(same ? KIND_OVERTAKE : KIND_MEET, xm1, m1);
        return pack_event(KIND_NONE, 0, 0);
      end
      if ((yh1 - ym1) * dxm == dym * (xh1 - xm1) && in_span(yh1, ym1, ym2)) begin
        mile = m1;
        if (dym > 0) mile = interp(m1, m2, yh1 - ym1, dym);
        else if (dym < 0) mile = interp(m1, m2, ym1 - yh1, -dym);
        return pack_event(same ? KIND_AVOID : KIND_MEET, xh1, mile);
      end
      return pack_event(KIND_NONE, 0, 0);
    end
    tn = dxh * (yh1 - ym1) - (xh1 - xm1) * dyh;
    sn = dxm * (yh1 - ym1) - (xh1 - xm1) * dym;
    if (det < 0) begin
      det = -det; tn = -tn; sn = -sn;
    end
    if (dym != 0 && (tn < 0 || tn > det)) return pack_event(KIND_NONE, 0, 0);
    if (dyh != 0 && (sn < 0 || sn > det)) return pack_event(KIND_NONE, 0, 0);
    if (dym != 0) t = interp(xm1, xm2, tn, det);
    else t = interp(xh1, xh2, sn, det);
    mile = m1;
    if (!vm && dym != 0) mile = interp(m1, m2, tn, det);
    if (!same) return pack_event(KIND_MEET, t, mile);
    if (vm) return pack_event(KIND_OVERTAKE, t, mile);
    if (vh) return pack_event(KIND_AVOID, t, mile);
    if (mag(dym) * mag(dxh) > mag(dyh) * mag(dxm)) return pack_event(KIND_OVERTAKE, t, mile);
    return pack_event(KIND_AVOID, t, mile);
  endfunction

  initial begin
    fail_count = 0;
    mismatches = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
  end

  assign pending = crossing_q.size();

  always @(posedge clk) begin
    crossing_t want;
    if (!rst) begin
      if (done) begin
        if (crossing_q.size() == 0) begin
          fail_count <= fail_count + 1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result kind %0d", event_kind);
        end else begin
          want = crossing_q.pop_front();
          if (event_kind != want.kind || event_time != want.t || event_mile != want.mile) begin
            fail_count <= fail_count + 1;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: kind %0d/%0d time %0d/%0d mile %0d/%0d (exp/got)",
                       want.kind, event_kind, want.t, event_time, want.mile, event_mile);
          end
          if (want.kind <= KIND_MEET) kind_seen[want.kind]++;
        end
      end
      if (start && !busy) crossing_q.insert(crossing_q.size(), predict_crossing());
    end
  end
endmodule

// ===== test/timetable_segment_crossing_unit_tb.sv =====
// Testbench top for the timetable segment crossing unit: stimulus and verdict
module timetable_segment_crossing_unit_tb
  import tsc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DAY = 86400000;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic mode = 1'b0;
  logic [TW-1:0] my_start_time = '0, my_end_time = '0, his_first_time = '0, his_second_time = '0;
  logic [YW-1:0] my_start_y = '0, my_end_y = '0, his_first_y = '0, his_second_y = '0;
  logic [MW-1:0] my_start_mile = '0, my_end_mile = '0, his_first_mile = '0;
  logic [2:0] event_kind;
  logic [TW-1:0] event_time;
  logic [MW-1:0] event_mile;
  int fail_count, pending;
  int kind_seen [5];
  int cycles = 0;
  int gap_pct = 0;

  always #2 clk = ~clk;

  timetable_segment_crossing_unit i_dut (.*);

  timetable_segment_crossing_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(bit md, int t1, int t2, int y1, int y2, int mi1, int mi2,
                           int h1, int h2, int hy1, int hy2, int hm);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    mode <= md;
    my_start_time <= TW'(t1); my_end_time <= TW'(t2);
    my_start_y <= YW'(y1); my_end_y <= YW'(y2);
    my_start_mile <= MW'(mi1); my_end_mile <= MW'(mi2);
    his_first_time <= TW'(h1); his_second_time <= TW'(h2);
    his_first_y <= YW'(hy1); his_second_y <= YW'(hy2);
    his_first_mile <= MW'(hm);
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int any_time();
    case ($urandom_range(4))
      0: return 0;
      1: return DAY - 1;
      2: return (1 << TW) - 1 - $urandom_range(100);
      default: return $urandom_range(DAY - 1);
    endcase
  endfunction

  task automatic random_item();
    int t1, t2, h1, h2, y1, y2, hy1, hy2, span;
    bit md;
    md = $urandom_range(1);
    if ($urandom_range(9) < 7) begin
      t1 = $urandom_range(DAY - 1);
      span = $urandom_range(3) == 0 ? 0 : $urandom_range(3600000);
      t2 = (t1 + span) % DAY;
      h1 = (t1 + $urandom_range(1200000) + DAY - 600000) % DAY;
      h2 = (h1 + ($urandom_range(3) == 0 ? 0 : $urandom_range(3600000))) % DAY;
      y1 = $urandom_range(1 << YW - 1);
      y2 = $urandom_range(1) ? y1 + $urandom_range(8000) : y1 - $urandom_range(8000);
      if ($urandom_range(7) == 0) y2 = y1;
      hy1 = y1 + $urandom_range(8000) - 4000;
      hy2 = $urandom_range(5) == 0 ? hy1 : y2 + $urandom_range(8000) - 4000;
      if ($urandom_range(9) == 0) begin
        h1 = t1; h2 = t2; hy1 = y1; hy2 = y2;
      end
      if (md) begin
        span = h1; h1 = h2; h2 = span;
      end
    end else begin
      t1 = any_time(); t2 = any_time(); h1 = any_time(); h2 = any_time();
      y1 = $urandom(); y2 = $urandom(); hy1 = $urandom(); hy2 = $urandom();
    end
    send_item(md, t1, t2, y1 & 20'hFFFFF, y2 & 20'hFFFFF, $urandom(), $urandom(),
              h1, h2, hy1 & 20'hFFFFF, hy2 & 20'hFFFFF, $urandom());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(1, (1<<TW)-1, (1<<TW)-1, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              (1<<TW)-1, (1<<TW)-1, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF);
    send_item(0, 1000, 5000, 0, 400, 100, 500, 1000, 5000, 0, 400, 7);
    send_item(0, 1000, 5000, 0, 400, 100, 500, 1000, 5000, 10, 410, 7);
    send_item(0, 1000, 9000, 0, 800, 0, 8000, 3000, 5000, 0, 800, 9);
    send_item(0, 1000, 9000, 0, 800, 0, 8000, 0, 12000, 0, 800, 9);
    send_item(1, 1000, 9000, 0, 800, 0, 8000, 9000, 1000, 800, 0, 9);
    send_item(0, 5000, 5000, 0, 800, 300, 900, 1000, 9000, 0, 800, 2);
    send_item(0, 1000, 9000, 0, 800, 300, 900, 5000, 5000, 0, 800, 2);
    send_item(0, 5000, 5000, 0, 800, 300, 900, 5000, 5000, 100, 900, 2);
    send_item(0, 1000, 9000, 0, 800, 0, 8000, 5000, 5000, 400, 400, 2);
    send_item(0, 5000, 5000, 400, 400, 0, 8000, 1000, 9000, 0, 800, 2);
    send_item(0, 1000, 9000, 300, 300, 40, 80, 2000, 6000, 0, 800, 2);
    send_item(0, DAY-1000, 3000, 0, 800, 0, 8000, DAY-500, 4000, 800, 0, 2);
    send_item(1, DAY-1000, 3000, 0, 800, 0, 8000, 4000, DAY-500, 800, 0, 2);
    send_item(0, 1000, 2000, 0, 8, 0, 8, 5000, 6000, 0, 8, 2);
    send_item(0, 1000, 9000, 800, 0, 24'hFFFFFF, 0, 1000, 9000, 0, 800, 2);
    for (int ph = 0; ph < 5; ph++) begin
      gap_pct = ph == 1 ? 71 : ph == 3 ? 23 : 0;
      for (int n = 0; n < 250; n++) random_item();
      start <= 1'b0;
      if (ph == 2) begin
        while (pending != 0) @(negedge clk);
      end
    end
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LAT + 5) @(negedge clk);
    $display("covered %0d none, %0d coincidence, %0d overtaking, %0d avoid, %0d meet",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
